/* rtl/frrc_pkg.sv */
// ----------------------------------------------------------------------------
// frrc_pkg
// Shared types, codes and helpers of the flash record ring controller.
// ----------------------------------------------------------------------------
package frrc_pkg;

	// sector layout
	localparam int HEADER_BYTES = 32;
	localparam int HEADER_WORDS = HEADER_BYTES / 4;

	// iterative divider geometry (sector size over record size)
	localparam int DIV_DVD_W = 17;
	localparam int DIV_DSR_W = 13;
	localparam int DIV_STEPS = DIV_DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_MOUNT = 2'd0,
		OP_SCAN  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_STATUS    = 3'd0,
		CMD_ERASE     = 3'd1,
		CMD_HEADER    = 3'd2,
		CMD_PROG_DATA = 3'd3,
		CMD_PROG_PTR  = 3'd4,
		CMD_READ      = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_TOO_LONG  = 3'd1,
		STS_UNALIGNED = 3'd2,
		STS_EMPTY     = 3'd3,
		STS_SCANNING  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_SECTOR_BASE  = 2'd0,
		CFG_SECTOR_BYTES = 2'd1,
		CFG_RECORD_BYTES = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_DIV1,
		S_DIV2,
		S_SCAN,
		S_SCAN_MUL,
		S_SCAN_FIN,
		S_ERASE,
		S_HEADER,
		S_WR_ADV,
		S_WR_DATA,
		S_WR_PTR,
		S_READ,
		S_STATUS
	} fsm_state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_in;
		logic    div_start;
		logic    div_sel;
		logic    latch_pbytes;
		logic    commit_layout;
		logic    scan_step;
		logic    mul_step;
		logic    finish_scan;
		logic    wr_restart;
		logic    wr_advance;
		logic    count_inc;
		logic    emit;
		cmd_t    emit_cmd;
		status_t emit_status;
		logic    emit_last;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  opcode;
		logic header_ok;
		logic scanning;
		logic rb_bad;
		logic len_too_long;
		logic len_unaligned;
		logic log_full;
		logic log_empty;
		logic div_done;
		logic scan_end;
		logic out_free;
	} dp_stat_t;

	// trailing zero count by halving, 31 for an all-zero word
	function automatic logic [4:0] trailing_zeros(input logic [31:0] w);
		logic [31:0] v;
		logic [4:0]  n;
		v = w;
		n = '0;
		if (v[15:0] == 16'd0) begin
			n[4] = 1'b1;
			v = v >> 16;
		end
		if (v[7:0] == 8'd0) begin
			n[3] = 1'b1;
			v = v >> 8;
		end
		if (v[3:0] == 4'd0) begin
			n[2] = 1'b1;
			v = v >> 4;
		end
		if (v[1:0] == 2'd0) begin
			n[1] = 1'b1;
			v = v >> 2;
		end
		if (v[0] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

/* rtl/frrc_div.sv */
// ----------------------------------------------------------------------------
// frrc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frrc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [frrc_pkg::DIV_DVD_W-1:0] dividend,
	input  logic [frrc_pkg::DIV_DSR_W-1:0] divisor,
	output logic                           done,
	output logic [frrc_pkg::DIV_DVD_W-1:0] quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [frrc_pkg::DIV_CNT_W-1:0] iter_q;
	logic [frrc_pkg::DIV_DSR_W-1:0] rem_q;
	logic [frrc_pkg::DIV_DVD_W-1:0] quo_q;
	logic [frrc_pkg::DIV_DSR_W-1:0] dsr_q;

	logic [frrc_pkg::DIV_DSR_W:0]   trial;
	logic [frrc_pkg::DIV_DSR_W:0]   diff;
	logic                           ge;

	assign trial = {rem_q, quo_q[frrc_pkg::DIV_DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= iter_q + 1'b1;
			if (iter_q == frrc_pkg::DIV_CNT_W'(frrc_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[frrc_pkg::DIV_DSR_W-1:0] : trial[frrc_pkg::DIV_DSR_W-1:0];
			quo_q <= {quo_q[frrc_pkg::DIV_DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/frrc_dp.sv */
// ----------------------------------------------------------------------------
// frrc_dp
// Datapath: configuration, layout and log state, result assembly and
// output register.
// ----------------------------------------------------------------------------
module frrc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [87:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	input  frrc_pkg::ctrl_cmd_t cmd,
	output frrc_pkg::dp_stat_t  stat,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [119:0]        m_tdata,
	output logic [2:0]          m_tuser,
	output logic                m_tlast
);

	// latched input item
	frrc_pkg::op_t op_q;
	logic          hdr_ok_q;
	logic [31:0]   pw_q;
	logic [15:0]   len_q;
	logic [31:0]   host_q;

	// configuration
	logic [31:0]   sector_base_q;
	logic [16:0]   sector_bytes_q;
	logic [12:0]   record_bytes_q;

	// log state
	logic [13:0]   record_count_q;
	logic [31:0]   current_addr_q;
	logic [13:0]   records_max_q;
	logic [31:0]   payload_base_q;
	logic [11:0]   paw_q;
	logic [11:0]   zws_q;
	logic          scanning_q;

	// working registers
	logic [13:0]   pbytes_q;
	logic [13:0]   cnt_q;
	logic [26:0]   prod_q;

	// output register
	logic          out_valid_q;
	frrc_pkg::cmd_t    out_cmd_q;
	logic [31:0]   out_flash_q;
	logic [31:0]   out_host_q;
	logic [14:0]   out_wc_q;
	logic [31:0]   out_pv_q;
	frrc_pkg::status_t out_sts_q;
	logic          out_last_q;

	logic [16:0]   avail;
	logic [16:0]   avail_rest;
	logic [16:0]   div_dvd;
	logic [16:0]   div_quo;
	logic          div_done;
	logic [13:0]   pb_sum;
	logic [13:0]   pb_calc;
	logic [31:0]   ptr_base;
	logic [31:0]   new_payload;

	logic [11:0]   zws_next;
	logic          pw_zero;
	logic [4:0]    tz;
	logic [16:0]   cnt_raw;
	logic [13:0]   cnt_sat;
	logic [13:0]   cnt_dec;
	logic [26:0]   prod_calc;

	logic [8:0]    ptr_q_idx;
	logic [4:0]    ptr_bit;
	logic [31:0]   ptr_off;
	logic [31:0]   ptr_addr;
	logic [31:0]   ptr_val;

	logic [31:0]   o_flash;
	logic [31:0]   o_host;
	logic [14:0]   o_wc;
	logic [31:0]   o_pv;

	// layout
	assign avail      = (sector_bytes_q > 17'(frrc_pkg::HEADER_BYTES)) ?
	                    sector_bytes_q - 17'(frrc_pkg::HEADER_BYTES) : '0;
	assign pb_sum     = div_quo[16:3] + 14'd4;
	assign pb_calc    = {pb_sum[13:2], 2'b00};
	assign avail_rest = (avail > {3'b000, pb_calc}) ? avail - {3'b000, pb_calc} : '0;
	assign div_dvd    = cmd.div_sel ? avail_rest : avail;
	assign ptr_base   = sector_base_q + 32'(frrc_pkg::HEADER_BYTES);
	assign new_payload = ptr_base + {18'd0, pbytes_q};

	frrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (record_bytes_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// pointer scan
	assign zws_next  = zws_q + 12'd1;
	assign pw_zero   = (pw_q == 32'd0);
	assign tz        = frrc_pkg::trailing_zeros(pw_q);
	assign cnt_raw   = pw_zero ? {zws_next, 5'd0} : {zws_q, 5'd0} + {12'd0, tz};
	assign cnt_sat   = (cnt_raw > {3'b000, records_max_q}) ? records_max_q : cnt_raw[13:0];
	assign cnt_dec   = cnt_q - 14'd1;
	assign prod_calc = cnt_dec * record_bytes_q;

	// thermometer word for the current count
	assign ptr_q_idx = record_count_q[13:5];
	assign ptr_bit   = record_count_q[4:0];
	assign ptr_off   = (ptr_bit == 5'd0) ? {23'd0, ptr_q_idx} - 32'd1 : {23'd0, ptr_q_idx};
	assign ptr_addr  = ptr_base + {ptr_off[29:0], 2'b00};
	assign ptr_val   = (ptr_bit == 5'd0) ? 32'd0 : 32'hFFFF_FFFF << ptr_bit;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= frrc_pkg::op_t'(s_tuser);
			hdr_ok_q <= s_tdata[0];
			pw_q     <= s_tdata[32:1];
			len_q    <= s_tdata[48:33];
			host_q   <= s_tdata[80:49];
		end
		if (cmd.latch_pbytes) begin
			pbytes_q <= pb_calc;
		end
		if (cmd.scan_step) begin
			cnt_q <= cnt_sat;
		end
		if (cmd.mul_step) begin
			prod_q <= prod_calc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_base_q  <= 32'd0;
			sector_bytes_q <= 17'd4096;
			record_bytes_q <= 13'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				frrc_pkg::CFG_SECTOR_BASE:  sector_base_q  <= cfg_data;
				frrc_pkg::CFG_SECTOR_BYTES: sector_bytes_q <= cfg_data[16:0];
				frrc_pkg::CFG_RECORD_BYTES: record_bytes_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q <= '0;
			current_addr_q <= '0;
			records_max_q  <= '0;
			payload_base_q <= '0;
			paw_q          <= '0;
			zws_q          <= '0;
			scanning_q     <= 1'b0;
		end else if (cmd.commit_layout) begin
			records_max_q  <= div_quo[13:0];
			paw_q          <= pbytes_q[13:2];
			payload_base_q <= new_payload;
			if (hdr_ok_q) begin
				scanning_q <= 1'b1;
				zws_q      <= '0;
			end else begin
				scanning_q     <= 1'b0;
				record_count_q <= '0;
				current_addr_q <= new_payload;
			end
		end else if (cmd.scan_step) begin
			if (pw_zero) begin
				zws_q <= zws_next;
			end
		end else if (cmd.finish_scan) begin
			record_count_q <= cnt_q;
			scanning_q     <= 1'b0;
			current_addr_q <= (cnt_q == 14'd0) ? payload_base_q :
			                  payload_base_q + {5'd0, prod_q};
		end else if (cmd.wr_restart) begin
			record_count_q <= '0;
			current_addr_q <= payload_base_q;
		end else if (cmd.wr_advance) begin
			current_addr_q <= (record_count_q == 14'd0) ? payload_base_q :
			                  current_addr_q + {19'd0, record_bytes_q};
		end else if (cmd.count_inc) begin
			record_count_q <= record_count_q + 14'd1;
		end
	end

	// result fields by command, unused fields stay zero
	always_comb begin
		o_flash = '0;
		o_host  = '0;
		o_wc    = '0;
		o_pv    = '0;
		case (cmd.emit_cmd)
			frrc_pkg::CMD_ERASE: begin
				o_flash = sector_base_q;
			end
			frrc_pkg::CMD_HEADER: begin
				o_flash = sector_base_q;
				o_wc    = 15'(frrc_pkg::HEADER_WORDS);
			end
			frrc_pkg::CMD_PROG_DATA, frrc_pkg::CMD_READ: begin
				o_flash = current_addr_q;
				o_host  = host_q;
				o_wc    = {1'b0, len_q[15:2]};
			end
			frrc_pkg::CMD_PROG_PTR: begin
				o_flash = ptr_addr;
				o_wc    = 15'd1;
				o_pv    = ptr_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_cmd_q   <= cmd.emit_cmd;
			out_flash_q <= o_flash;
			out_host_q  <= o_host;
			out_wc_q    <= o_wc;
			out_pv_q    <= o_pv;
			out_sts_q   <= cmd.emit_status;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_sts_q, out_pv_q, out_wc_q, out_host_q, out_flash_q};
	assign m_tuser  = out_cmd_q;
	assign m_tlast  = out_last_q;

	assign stat.opcode        = op_q;
	assign stat.header_ok     = hdr_ok_q;
	assign stat.scanning      = scanning_q;
	assign stat.rb_bad        = (record_bytes_q[1:0] != 2'd0) || (record_bytes_q == 13'd0);
	assign stat.len_too_long  = len_q > {3'b000, record_bytes_q};
	assign stat.len_unaligned = len_q[1:0] != 2'd0;
	assign stat.log_full      = record_count_q >= records_max_q;
	assign stat.log_empty     = record_count_q == 14'd0;
	assign stat.div_done      = div_done;
	assign stat.scan_end      = !pw_zero || (zws_next >= paw_q);
	assign stat.out_free      = !out_valid_q || m_tready;

endmodule

/* rtl/frrc_ctrl.sv */
// ----------------------------------------------------------------------------
// frrc_ctrl
// Controller: sequences one item at a time through mount, scan, write and
// read, and emits its result items through the output register.
// ----------------------------------------------------------------------------
module frrc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  frrc_pkg::dp_stat_t  stat,
	output logic                in_ready,
	output frrc_pkg::ctrl_cmd_t cmd
);

	frrc_pkg::fsm_state_t state_q, state_d;
	frrc_pkg::status_t    sts_q, sts_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frrc_pkg::S_IDLE;
			sts_q   <= frrc_pkg::STS_OK;
		end else begin
			state_q <= state_d;
			sts_q   <= sts_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		sts_d   = sts_q;
		case (state_q)
			frrc_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = frrc_pkg::S_DECODE;
				end
			end
			frrc_pkg::S_DECODE: begin
				case (stat.opcode)
					frrc_pkg::OP_MOUNT: begin
						if (stat.rb_bad) begin
							state_d = frrc_pkg::S_STATUS;
							sts_d   = frrc_pkg::STS_UNALIGNED;
						end else begin
							state_d = frrc_pkg::S_DIV1;
						end
					end
					frrc_pkg::OP_SCAN: begin
						state_d = frrc_pkg::S_SCAN;
					end
					frrc_pkg::OP_WRITE: begin
						state_d = frrc_pkg::S_STATUS;
						if (stat.scanning) begin
							sts_d = frrc_pkg::STS_SCANNING;
						end else if (stat.len_too_long) begin
							sts_d = frrc_pkg::STS_TOO_LONG;
						end else if (stat.len_unaligned) begin
							sts_d = frrc_pkg::STS_UNALIGNED;
						end else if (stat.log_full) begin
							state_d = frrc_pkg::S_ERASE;
						end else begin
							state_d = frrc_pkg::S_WR_ADV;
						end
					end
					default: begin
						state_d = frrc_pkg::S_STATUS;
						if (stat.scanning) begin
							sts_d = frrc_pkg::STS_SCANNING;
						end else if (stat.log_empty) begin
							sts_d = frrc_pkg::STS_EMPTY;
						end else if (stat.len_too_long) begin
							sts_d = frrc_pkg::STS_TOO_LONG;
						end else if (stat.len_unaligned) begin
							sts_d = frrc_pkg::STS_UNALIGNED;
						end else begin
							state_d = frrc_pkg::S_READ;
						end
					end
				endcase
			end
			frrc_pkg::S_DIV1: begin
				if (stat.div_done) begin
					state_d = frrc_pkg::S_DIV2;
				end
			end
			frrc_pkg::S_DIV2: begin
				if (stat.div_done) begin
					if (stat.header_ok) begin
						state_d = frrc_pkg::S_STATUS;
						sts_d   = frrc_pkg::STS_SCANNING;
					end else begin
						state_d = frrc_pkg::S_ERASE;
					end
				end
			end
			frrc_pkg::S_SCAN: begin
				if (!stat.scanning) begin
					state_d = frrc_pkg::S_IDLE;
				end else if (stat.scan_end) begin
					state_d = frrc_pkg::S_SCAN_MUL;
				end else begin
					state_d = frrc_pkg::S_STATUS;
					sts_d   = frrc_pkg::STS_SCANNING;
				end
			end
			frrc_pkg::S_SCAN_MUL: begin
				state_d = frrc_pkg::S_SCAN_FIN;
			end
			frrc_pkg::S_SCAN_FIN: begin
				state_d = frrc_pkg::S_STATUS;
				sts_d   = frrc_pkg::STS_OK;
			end
			frrc_pkg::S_ERASE: begin
				if (stat.out_free) begin
					state_d = frrc_pkg::S_HEADER;
				end
			end
			frrc_pkg::S_HEADER: begin
				if (stat.out_free) begin
					state_d = (stat.opcode == frrc_pkg::OP_WRITE) ?
					          frrc_pkg::S_WR_ADV : frrc_pkg::S_IDLE;
				end
			end
			frrc_pkg::S_WR_ADV: begin
				state_d = frrc_pkg::S_WR_DATA;
			end
			frrc_pkg::S_WR_DATA: begin
				if (stat.out_free) begin
					state_d = frrc_pkg::S_WR_PTR;
				end
			end
			frrc_pkg::S_WR_PTR, frrc_pkg::S_READ, frrc_pkg::S_STATUS: begin
				if (stat.out_free) begin
					state_d = frrc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = frrc_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			frrc_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			frrc_pkg::S_DECODE: begin
				if (stat.opcode == frrc_pkg::OP_MOUNT && !stat.rb_bad) begin
					cmd.div_start = 1'b1;
				end
			end
			frrc_pkg::S_DIV1: begin
				if (stat.div_done) begin
					cmd.latch_pbytes = 1'b1;
					cmd.div_start    = 1'b1;
					cmd.div_sel      = 1'b1;
				end
			end
			frrc_pkg::S_DIV2: begin
				cmd.commit_layout = stat.div_done;
			end
			frrc_pkg::S_SCAN: begin
				cmd.scan_step = stat.scanning;
			end
			frrc_pkg::S_SCAN_MUL: begin
				cmd.mul_step = 1'b1;
			end
			frrc_pkg::S_SCAN_FIN: begin
				cmd.finish_scan = 1'b1;
			end
			frrc_pkg::S_ERASE: begin
				cmd.emit     = stat.out_free;
				cmd.emit_cmd = frrc_pkg::CMD_ERASE;
			end
			frrc_pkg::S_HEADER: begin
				cmd.emit       = stat.out_free;
				cmd.emit_cmd   = frrc_pkg::CMD_HEADER;
				cmd.emit_last  = (stat.opcode == frrc_pkg::OP_MOUNT);
				cmd.wr_restart = stat.out_free && (stat.opcode == frrc_pkg::OP_WRITE);
			end
			frrc_pkg::S_WR_ADV: begin
				cmd.wr_advance = 1'b1;
			end
			frrc_pkg::S_WR_DATA: begin
				cmd.emit      = stat.out_free;
				cmd.emit_cmd  = frrc_pkg::CMD_PROG_DATA;
				cmd.count_inc = stat.out_free;
			end
			frrc_pkg::S_WR_PTR: begin
				cmd.emit      = stat.out_free;
				cmd.emit_cmd  = frrc_pkg::CMD_PROG_PTR;
				cmd.emit_last = 1'b1;
			end
			frrc_pkg::S_READ: begin
				cmd.emit      = stat.out_free;
				cmd.emit_cmd  = frrc_pkg::CMD_READ;
				cmd.emit_last = 1'b1;
			end
			frrc_pkg::S_STATUS: begin
				cmd.emit        = stat.out_free;
				cmd.emit_cmd    = frrc_pkg::CMD_STATUS;
				cmd.emit_status = sts_q;
				cmd.emit_last   = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/flash_record_ring_controller.sv */
// ----------------------------------------------------------------------------
// flash_record_ring_controller
// Command sequencer for a one-sector ring of fixed-size flash records with a
// thermometer-coded record count in a pointer area after the header.
// ----------------------------------------------------------------------------
// sequence: mount runs two 17-step divisions by record size in the shared
//   restoring divider; a scan item with no scan open is ignored without a
//   result; a write erases the sector and rewrites the header on a ring wrap
//   before its data program; one item at a time, results wait for a free output
// reset: arst_n clears the log state and the controller, configuration
//   returns to base 0, 4096-byte sector, 16-byte records
// ----------------------------------------------------------------------------
module flash_record_ring_controller (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,   // header_ok, pointer_word, length_bytes, host_buffer_addr
	input  logic [1:0]   s_tuser,   // opcode
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // flash_addr, host_addr, word_count, pointer_value, status
	output logic [2:0]   m_tuser,   // command
	output logic         m_tlast    // last result of the item
);

	frrc_pkg::ctrl_cmd_t ctrl_cmd;
	frrc_pkg::dp_stat_t  dp_stat;

	// configuration registers are always writable
	assign cfg_ready = 1'b1;

	// controller: one item in flight, ready only when idle
	frrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (dp_stat),
		.in_ready (s_tready),
		.cmd      (ctrl_cmd)
	);

	// datapath: layout, count recovery, address math and the output register,
	// which lets the next item be taken while the last result waits
	frrc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	// a new item is never taken in the cycle right after one was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
	else $error("item accepted twice in a row");

	// results only load into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.emit |-> dp_stat.out_free)
	else $error("output register overwritten");

	// no data program while the pointer scan is open
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_cmd.emit && ctrl_cmd.emit_cmd == frrc_pkg::CMD_PROG_DATA) |-> !dp_stat.scanning)
	else $error("data program during scan");

	// the pointer word program closes a write
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == frrc_pkg::CMD_PROG_PTR) |-> m_tlast)
	else $error("pointer program not marked last");
`endif

endmodule
